// ----- hw/rtl/mexp_pkg.sv -----
// ----------------------------------------------------------------------------
// mexp_pkg: shared types and constants for modular exponentiation
// Holds operand widths, reducer sizing, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package mexp_pkg;

	localparam int unsigned DATA_W    = 32;
	localparam int unsigned PROD_W    = 2 * DATA_W;
	// dividend bits retired by the reducer per cycle
	localparam int unsigned RED_BITS  = 2;
	localparam int unsigned RED_STEPS = PROD_W / RED_BITS;
	localparam int unsigned RED_CNT_W = $clog2(RED_STEPS);

	typedef enum logic [1:0] {
		MUL_PASS,
		MUL_ACC,
		MUL_SQR
	} mul_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_GO_BASE,
		ST_RED_BASE,
		ST_BIT,
		ST_GO_ACC,
		ST_RED_ACC,
		ST_MUL_SQR,
		ST_GO_SQR,
		ST_RED_SQR,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic    load;
		logic    mul_en;
		mul_op_t mul_op;
		logic    red_start;
		logic    wr_acc;
		logic    wr_base;
		logic    shift_exp;
		logic    clr_acc;
		logic    res_wr;
	} cmd_t;

	typedef struct packed {
		logic m_zero;
		logic e_zero;
		logic e_lsb;
		logic red_busy;
		logic red_done;
		logic out_free;
	} status_t;

endpackage

// ----- hw/rtl/mexp_red.sv -----
// ----------------------------------------------------------------------------
// mexp_red: serial modular reducer
// Restoring division of a 64-bit product by the modulus, RED_BITS dividend
// bits per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
module mexp_red (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [mexp_pkg::PROD_W-1:0]     dvd,
	input  logic [mexp_pkg::DATA_W-1:0]     m,
	output logic [mexp_pkg::DATA_W-1:0]     rem,
	output logic                            busy,
	output logic                            done
);

	logic [mexp_pkg::PROD_W-1:0]    dvd_q;
	logic [mexp_pkg::DATA_W-1:0]    rem_q;
	logic [mexp_pkg::DATA_W-1:0]    rem_d;
	logic [mexp_pkg::RED_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;

	// remainder stays below m, so each shifted value is below 2m: one subtract
	always_comb begin
		logic [mexp_pkg::DATA_W:0]   t;
		logic [mexp_pkg::DATA_W-1:0] r;
		r = rem_q;
		for (int i = 0; i < int'(mexp_pkg::RED_BITS); i++) begin
			t = {r, dvd_q[mexp_pkg::PROD_W-1-i]};
			if (t >= {1'b0, m}) begin
				t = t - {1'b0, m};
			end
			r = t[mexp_pkg::DATA_W-1:0];
		end
		rem_d = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == mexp_pkg::RED_CNT_W'(mexp_pkg::RED_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dvd;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << mexp_pkg::RED_BITS;
			rem_q <= rem_d;
		end
	end

	assign rem  = rem_q;
	assign busy = busy_q;
	assign done = done_q;

endmodule

// ----- hw/rtl/mexp_dpath.sv -----
// ----------------------------------------------------------------------------
// mexp_dpath: operand registers, multiplier, reducer and output register
// Executes the commands of the controller and reports status back.
// ----------------------------------------------------------------------------
module mexp_dpath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mexp_pkg::cmd_t              cmd,
	output mexp_pkg::status_t           status,
	input  logic [mexp_pkg::DATA_W-1:0] base,
	input  logic [mexp_pkg::DATA_W-1:0] exponent,
	input  logic [mexp_pkg::DATA_W-1:0] modulus,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [mexp_pkg::DATA_W-1:0] residue,
	output logic                        bad_modulus
);

	logic [mexp_pkg::DATA_W-1:0] base_q;
	logic [mexp_pkg::DATA_W-1:0] exp_q;
	logic [mexp_pkg::DATA_W-1:0] mod_q;
	logic [mexp_pkg::DATA_W-1:0] acc_q;
	logic [mexp_pkg::PROD_W-1:0] prod_q;
	logic [mexp_pkg::DATA_W-1:0] res_q;
	logic                        bad_q;
	logic                        out_valid_q;

	logic [mexp_pkg::DATA_W-1:0] mul_a;
	logic [mexp_pkg::DATA_W-1:0] mul_b;
	logic [mexp_pkg::DATA_W-1:0] red_rem;
	logic                        red_busy;
	logic                        red_done;
	logic                        out_free;

	always_comb begin
		case (cmd.mul_op)
			mexp_pkg::MUL_PASS: begin
				mul_a = base_q;
				mul_b = mexp_pkg::DATA_W'(1);
			end
			mexp_pkg::MUL_ACC: begin
				mul_a = acc_q;
				mul_b = base_q;
			end
			mexp_pkg::MUL_SQR: begin
				mul_a = base_q;
				mul_b = base_q;
			end
			default: begin
				mul_a = base_q;
				mul_b = base_q;
			end
		endcase
	end

	mexp_red u_red (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.red_start),
		.dvd    (prod_q),
		.m      (mod_q),
		.rem    (red_rem),
		.busy   (red_busy),
		.done   (red_done)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			base_q <= base;
			exp_q  <= exponent;
			mod_q  <= modulus;
		end else begin
			if (cmd.wr_base) begin
				base_q <= red_rem;
			end
			if (cmd.shift_exp) begin
				exp_q <= exp_q >> 1;
			end
		end
		if (cmd.load) begin
			acc_q <= mexp_pkg::DATA_W'(1);
		end else if (cmd.clr_acc) begin
			acc_q <= '0;
		end else if (cmd.wr_acc) begin
			acc_q <= red_rem;
		end
		if (cmd.mul_en) begin
			prod_q <= mexp_pkg::PROD_W'(mul_a) * mexp_pkg::PROD_W'(mul_b);
		end
		if (cmd.res_wr) begin
			res_q <= acc_q;
			bad_q <= status.m_zero;
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_wr) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.m_zero   = (mod_q == '0);
	assign status.e_zero   = (exp_q == '0);
	assign status.e_lsb    = exp_q[0];
	assign status.red_busy = red_busy;
	assign status.red_done = red_done;
	assign status.out_free = out_free;

	assign out_valid   = out_valid_q;
	assign residue     = res_q;
	assign bad_modulus = bad_q;

endmodule

// ----- hw/rtl/mexp_ctrl.sv -----
// ----------------------------------------------------------------------------
// mexp_ctrl: square-and-multiply sequencer
// Walks the exponent bits and issues multiply and reduce commands.
// ----------------------------------------------------------------------------
module mexp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  mexp_pkg::status_t status,
	output mexp_pkg::cmd_t    cmd
);

	mexp_pkg::state_t state_q;
	mexp_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mexp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			mexp_pkg::ST_IDLE: begin
				if (in_valid) state_d = mexp_pkg::ST_START;
			end
			mexp_pkg::ST_START: begin
				if (status.m_zero || status.e_zero) state_d = mexp_pkg::ST_OUT;
				else state_d = mexp_pkg::ST_GO_BASE;
			end
			mexp_pkg::ST_GO_BASE: state_d = mexp_pkg::ST_RED_BASE;
			mexp_pkg::ST_RED_BASE: begin
				if (status.red_done) state_d = mexp_pkg::ST_BIT;
			end
			mexp_pkg::ST_BIT: begin
				if (status.e_zero) state_d = mexp_pkg::ST_OUT;
				else if (status.e_lsb) state_d = mexp_pkg::ST_GO_ACC;
				else state_d = mexp_pkg::ST_GO_SQR;
			end
			mexp_pkg::ST_GO_ACC: state_d = mexp_pkg::ST_RED_ACC;
			mexp_pkg::ST_RED_ACC: begin
				if (status.red_done) state_d = mexp_pkg::ST_MUL_SQR;
			end
			mexp_pkg::ST_MUL_SQR: state_d = mexp_pkg::ST_GO_SQR;
			mexp_pkg::ST_GO_SQR: state_d = mexp_pkg::ST_RED_SQR;
			mexp_pkg::ST_RED_SQR: begin
				if (status.red_done) state_d = mexp_pkg::ST_BIT;
			end
			mexp_pkg::ST_OUT: begin
				if (status.out_free) state_d = mexp_pkg::ST_IDLE;
			end
			default: state_d = mexp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = (state_q != mexp_pkg::ST_IDLE);
		case (state_q)
			mexp_pkg::ST_IDLE: begin
				cmd.load = in_valid;
			end
			mexp_pkg::ST_START: begin
				if (status.m_zero) begin
					cmd.clr_acc = 1'b1;
				end else if (!status.e_zero) begin
					cmd.mul_en = 1'b1;
					cmd.mul_op = mexp_pkg::MUL_PASS;
				end
			end
			mexp_pkg::ST_GO_BASE, mexp_pkg::ST_GO_ACC, mexp_pkg::ST_GO_SQR: begin
				cmd.red_start = 1'b1;
			end
			mexp_pkg::ST_RED_BASE: begin
				cmd.wr_base = status.red_done;
			end
			mexp_pkg::ST_BIT: begin
				if (!status.e_zero) begin
					cmd.mul_en = 1'b1;
					cmd.mul_op = status.e_lsb ? mexp_pkg::MUL_ACC : mexp_pkg::MUL_SQR;
				end
			end
			mexp_pkg::ST_RED_ACC: begin
				cmd.wr_acc = status.red_done;
			end
			mexp_pkg::ST_MUL_SQR: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = mexp_pkg::MUL_SQR;
			end
			mexp_pkg::ST_RED_SQR: begin
				cmd.wr_base   = status.red_done;
				cmd.shift_exp = status.red_done;
			end
			mexp_pkg::ST_OUT: begin
				cmd.res_wr = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ----- hw/rtl/modular_exponentiation.sv -----
// ----------------------------------------------------------------------------
// modular_exponentiation: base^exponent mod modulus, one item at a time
// Sequence: a zero modulus or exponent goes straight to the output; else the base is
// reduced once, then each exponent bit up to the top set bit costs a squaring step and
// each set bit a multiply step; each step is a multiply and 64-bit reduction (2-bit reducer).
// Throughput: the next item is taken as soon as the result sits in the output register.
// Reset clears the sequencer and the output valid; operand registers are not reset.
// ----------------------------------------------------------------------------
module modular_exponentiation (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [mexp_pkg::DATA_W-1:0] base,
	input  logic [mexp_pkg::DATA_W-1:0] exponent,
	input  logic [mexp_pkg::DATA_W-1:0] modulus,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [mexp_pkg::DATA_W-1:0] residue,
	output logic                        bad_modulus
);

	// Flow of one item:
	//   accept  -> latch base, exponent, modulus; accumulator preset to one
	//   start   -> zero modulus: clear accumulator, flag error, go deliver
	//              zero exponent: deliver the preset one unreduced
	//              otherwise pass the base through the multiplier and reduce it
	//   per bit -> set bit: acc = acc*base mod m; always: base = base^2 mod m,
	//              then drop the exponent's low bit
	//   deliver -> load the output register once it is free
	// The output register parts the two sides: a new item can be accepted
	// while the previous result still waits for the downstream side.

	mexp_pkg::cmd_t    cmd;
	mexp_pkg::status_t status;

	// sequencer: owns the input handshake, drives the datapath
	mexp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath: operands, 32x32 multiplier, serial reducer, output register
	mexp_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.base        (base),
		.exponent    (exponent),
		.modulus     (modulus),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.residue     (residue),
		.bad_modulus (bad_modulus)
	);

	// one item in flight: an accepted item blocks further input next cycle
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted while an item is in flight");

	// reducer is never restarted mid-division
	a_red_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.red_start |-> !status.red_busy)
		else $error("reducer started while busy");

	// result is only written into a free output register
	a_res_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_wr |-> status.out_free)
		else $error("result overwrote an undelivered item");

	// error results always carry a zero residue
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && bad_modulus) |-> (residue == '0))
		else $error("bad modulus with nonzero residue");

endmodule
